// ===== rtl/mofb_pkg.sv =====
// shared types and constants for the mono panel frame buffer engine
`default_nettype none

package mofb_pkg;

	// operation codes
	localparam logic [2:0] OP_POINT     = 3'd0;
	localparam logic [2:0] OP_FILL      = 3'd1;
	localparam logic [2:0] OP_CLEAR     = 3'd2;
	localparam logic [2:0] OP_REF_START = 3'd3;
	localparam logic [2:0] OP_REF_NEXT  = 3'd4;
	localparam logic [2:0] OP_POWER     = 3'd5;

	// panel controller command bytes
	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_LO    = 8'h00;
	localparam logic [7:0] CMD_COL_HI    = 8'h10;
	localparam logic [7:0] CMD_PUMP      = 8'h8D;
	localparam logic [7:0] CMD_PUMP_ON   = 8'h14;
	localparam logic [7:0] CMD_PUMP_OFF  = 8'h10;
	localparam logic [7:0] CMD_DISP_ON   = 8'hAF;
	localparam logic [7:0] CMD_DISP_OFF  = 8'hAE;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_WR,
		ST_REF,
		ST_PWR
	} seq_state_t;

	// buffer port controls
	typedef struct packed {
		logic rd;
		logic wr;
		logic zero;
		logic set;
	} mem_ctl_t;

	// one result leaving the sequencer
	typedef struct packed {
		logic valid;
		logic from_mem;
		logic is_data;
		logic last;
		logic fend;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/mono_oled_frame_buffer_engine.sv =====
// top level of the mono panel frame buffer engine
`default_nettype none

// A one-bit COLUMNS x (PAGES*8) image kept as column bytes, one byte per
// column per page; screen row y sits in page PAGES-1-y/8 at bit 7-y%8. A
// transaction is taken on a clock edge with start high and busy low, and busy
// stays high until the block can take the next one. Results come out at most
// one per cycle on out_byte/is_data/run_last/frame_end, flagged by strobe for
// exactly one cycle; the receiver cannot stall them, so it must sample on
// every strobe. A point is one buffer read and one merged write, a rectangle
// a read and a merged write for every touched byte (columns x covered
// pages), and a whole clear sweeps the single write port over all
// 2^(clog2(PAGES)+clog2(COLUMNS)) byte addresses, one byte per cycle. A
// refresh command byte needs no buffer access and leaves busy low, a refresh
// data byte comes from a registered buffer read, and start refresh and
// ignored codes leave busy low; display power sends its three commands on
// consecutive cycles. Each result strobes in the cycle after the one that
// produced it. After reset the same clearing sweep runs first with busy
// high. Drawing during a refresh lands in the buffer at once, so bytes not
// yet streamed show it. A refresh byte request while no refresh runs gives
// no result.
module mono_oled_frame_buffer_engine
	import mofb_pkg::*;
#(
	parameter int COLUMNS = 128,
	parameter int PAGES = 8
) (
	input  wire  logic          clk,
	input  wire  logic          arst_n,
	input  wire  logic          start,
	output logic                busy,
	input  wire  logic [2:0]    operation,
	input  wire  logic [7:0]    x_start,
	input  wire  logic [7:0]    y_start,
	input  wire  logic [7:0]    x_end,
	input  wire  logic [7:0]    y_end,
	input  wire  logic          pixel_value,
	output logic                strobe,
	output logic [7:0]          out_byte,
	output logic                is_data,
	output logic                run_last,
	output logic                frame_end
);

	localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int CW = $clog2(COLUMNS);
	localparam int AW = PW + CW;

	mem_ctl_t      mem_ctl;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_mask;
	logic [7:0]    rd_data;
	res_t          res;
	logic [7:0]    res_byte;

	// output stage registers
	logic       strobe_q;
	logic [7:0] out_byte_q;
	logic       is_data_q;
	logic       run_last_q;
	logic       frame_end_q;

	// sequencer: decode, rectangle walk, clear sweep, refresh position
	mofb_seq #(
		.COLUMNS(COLUMNS),
		.PAGES  (PAGES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.operation  (operation),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.pixel_value(pixel_value),
		.busy       (busy),
		.mem_ctl    (mem_ctl),
		.mem_addr   (mem_addr),
		.mem_mask   (mem_mask),
		.res        (res),
		.res_byte   (res_byte)
	);

	// the frame buffer and its shared read-modify-write merge
	mofb_store #(
		.AW(AW)
	) u_store (
		.clk    (clk),
		.ctl    (mem_ctl),
		.addr   (mem_addr),
		.mask   (mem_mask),
		.rd_data(rd_data)
	);

	// strobe is control and comes out of reset low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= res.valid;
		end
	end

	// data bytes come straight from the registered buffer read
	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_byte_q  <= res.from_mem ? rd_data : res_byte;
			is_data_q   <= res.is_data;
			run_last_q  <= res.last;
			frame_end_q <= res.fend;
		end
	end

	assign strobe    = strobe_q;
	assign out_byte  = out_byte_q;
	assign is_data   = is_data_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

endmodule

`default_nettype wire

// ===== rtl/mofb_store.sv =====
// frame buffer memory with registered read and read-modify-write merge
`default_nettype none

module mofb_store
	import mofb_pkg::*;
#(
	parameter int AW = 10
) (
	input  wire  logic            clk,
	input  wire  mem_ctl_t        ctl,
	input  wire  logic [AW-1:0]   addr,
	input  wire  logic [7:0]      mask,
	output logic [7:0]            rd_data
);

	logic [7:0] mem_q [2**AW];
	logic [7:0] rd_data_q;
	logic [7:0] wr_data;

	// merge the byte from the registered read with the pixel mask, or write zero for a clear
	always_comb begin
		if (ctl.zero) begin
			wr_data = 8'h00;
		end else if (ctl.set) begin
			wr_data = rd_data_q | mask;
		end else begin
			wr_data = rd_data_q & ~mask;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_data_q <= mem_q[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/mofb_seq.sv =====
// sequencer: decode, rectangle walk, clear sweep, refresh and power streams
`default_nettype none

module mofb_seq
	import mofb_pkg::*;
#(
	parameter int COLUMNS = 128,
	parameter int PAGES = 8,
	localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1,
	localparam int CW = $clog2(COLUMNS),
	localparam int AW = PW + CW,
	localparam int OW = $clog2(COLUMNS + 3)
) (
	input  wire  logic          clk,
	input  wire  logic          arst_n,
	input  wire  logic          start,
	input  wire  logic [2:0]    operation,
	input  wire  logic [7:0]    x_start,
	input  wire  logic [7:0]    y_start,
	input  wire  logic [7:0]    x_end,
	input  wire  logic [7:0]    y_end,
	input  wire  logic          pixel_value,
	output logic                busy,
	output mem_ctl_t            mem_ctl,
	output logic [AW-1:0]       mem_addr,
	output logic [7:0]          mem_mask,
	output res_t                res,
	output logic [7:0]          res_byte
);

	localparam logic [7:0]    XMAX     = 8'(COLUMNS - 1);
	localparam logic [7:0]    YMAX     = 8'(PAGES * 8 - 1);
	localparam logic [PW-1:0] PMAX     = PW'(PAGES - 1);
	localparam logic [OW-1:0] OFF_DATA = OW'(3);
	localparam logic [OW-1:0] OFF_LAST = OW'(COLUMNS + 2);

	seq_state_t state_q, state_d;

	logic [AW-1:0] clr_q;
	logic          ref_active_q;
	logic [PW-1:0] page_q;
	logic [OW-1:0] off_q;
	logic [1:0]    cnt_q;

	logic [7:0]    x_q, xe_q;
	logic [PW-1:0] b_q, bs_q, be_q;
	logic [2:0]    ylo_q, yhi_q;
	logic          on_q;

	logic          accept;
	logic [7:0]    xe_sel, ye_sel, xe_c, ye_c;
	logic          rect_empty;
	logic          rect_last;
	logic          ref_cmd;
	logic          ref_adv;
	logic [2:0]    lo, hi;
	logic [AW-1:0] rect_addr, ref_addr;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// clip the rectangle; a point is a one-pixel rectangle
	always_comb begin
		xe_sel = (operation == OP_POINT) ? x_start : x_end;
		ye_sel = (operation == OP_POINT) ? y_start : y_end;
		xe_c   = (xe_sel > XMAX) ? XMAX : xe_sel;
		ye_c   = (ye_sel > YMAX) ? YMAX : ye_sel;
		rect_empty = (x_start > xe_c) || (y_start > ye_c);
	end

	assign rect_last = (b_q == be_q) && (x_q == xe_q);

	// row mask inside the current row block
	always_comb begin
		lo = (b_q == bs_q) ? ylo_q : 3'd0;
		hi = (b_q == be_q) ? yhi_q : 3'd7;
		mem_mask = (8'hFF >> lo) & (8'hFF << (3'd7 - hi));
	end

	assign rect_addr = {PW'(PMAX - b_q), x_q[CW-1:0]};
	assign ref_addr  = {page_q, CW'(off_q - OFF_DATA)};

	assign ref_cmd = accept && (operation == OP_REF_NEXT) && ref_active_q && (off_q < OFF_DATA);
	assign ref_adv = ref_cmd || (state_q == ST_REF);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (operation)
						OP_POINT, OP_FILL: begin
							if (!rect_empty) begin
								state_d = ST_RD;
							end
						end
						OP_CLEAR: state_d = ST_CLEAR;
						OP_REF_NEXT: begin
							if (ref_active_q && (off_q >= OFF_DATA)) begin
								state_d = ST_REF;
							end
						end
						OP_POWER: state_d = ST_PWR;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD: state_d = ST_WR;
			ST_WR: state_d = rect_last ? ST_IDLE : ST_RD;
			ST_REF: state_d = ST_IDLE;
			ST_PWR: begin
				if (cnt_q == 2'd2) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mem_ctl  = '0;
		mem_addr = rect_addr;
		res      = '0;
		res_byte = 8'h00;
		case (state_q)
			ST_CLEAR: begin
				mem_ctl.wr   = 1'b1;
				mem_ctl.zero = 1'b1;
				mem_addr     = clr_q;
			end
			ST_IDLE: begin
				mem_addr = ref_addr;
				if (ref_cmd) begin
					res.valid = 1'b1;
					res.last  = 1'b1;
					case (off_q[1:0])
						2'd0: res_byte = CMD_PAGE_BASE + 8'(page_q);
						2'd1: res_byte = CMD_COL_LO;
						default: res_byte = CMD_COL_HI;
					endcase
				end else if (accept && (operation == OP_REF_NEXT) && ref_active_q) begin
					mem_ctl.rd = 1'b1;
				end
			end
			ST_RD: begin
				mem_ctl.rd = 1'b1;
			end
			ST_WR: begin
				mem_ctl.wr  = 1'b1;
				mem_ctl.set = on_q;
			end
			ST_REF: begin
				res.valid    = 1'b1;
				res.from_mem = 1'b1;
				res.is_data  = 1'b1;
				res.last     = 1'b1;
				res.fend     = (page_q == PMAX) && (off_q == OFF_LAST);
			end
			ST_PWR: begin
				res.valid = 1'b1;
				res.last  = (cnt_q == 2'd2);
				case (cnt_q)
					2'd0: res_byte = CMD_PUMP;
					2'd1: res_byte = on_q ? CMD_PUMP_ON : CMD_PUMP_OFF;
					default: res_byte = on_q ? CMD_DISP_ON : CMD_DISP_OFF;
				endcase
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			ref_active_q <= 1'b0;
			page_q       <= '0;
			off_q        <= '0;
			cnt_q        <= 2'd0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					if (accept) begin
						case (operation)
							OP_CLEAR: clr_q <= '0;
							OP_REF_START: begin
								ref_active_q <= 1'b1;
								page_q       <= '0;
								off_q        <= '0;
							end
							OP_POWER: cnt_q <= 2'd0;
							default: ;
						endcase
					end
				end
				ST_PWR: cnt_q <= cnt_q + 2'd1;
				default: ;
			endcase
			if (ref_adv) begin
				if (off_q == OFF_LAST) begin
					off_q <= '0;
					if (page_q == PMAX) begin
						page_q       <= '0;
						ref_active_q <= 1'b0;
					end else begin
						page_q <= page_q + 1'b1;
					end
				end else begin
					off_q <= off_q + 1'b1;
				end
			end
		end
	end

	// rectangle walk: columns outer, row blocks inner
	always_ff @(posedge clk) begin
		if (accept && ((operation == OP_POINT) || (operation == OP_FILL))) begin
			x_q   <= x_start;
			xe_q  <= xe_c;
			bs_q  <= y_start[PW+2:3];
			b_q   <= y_start[PW+2:3];
			be_q  <= ye_c[PW+2:3];
			ylo_q <= y_start[2:0];
			yhi_q <= ye_c[2:0];
			on_q  <= pixel_value;
		end else if (accept && (operation == OP_POWER)) begin
			on_q <= pixel_value;
		end else if (state_q == ST_WR) begin
			if (b_q == be_q) begin
				b_q <= bs_q;
				x_q <= x_q + 8'd1;
			end else begin
				b_q <= b_q + 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> ($past(state_q) == ST_RD))
		else $error("buffer write without preceding read");

	a_quiet_while_drawing: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RD) || (state_q == ST_WR) || (state_q == ST_CLEAR)) |-> !res.valid)
		else $error("result raised during draw or clear");

	a_fend_form: assert property (@(posedge clk) disable iff (!arst_n)
		res.fend |-> (res.is_data && res.last && res.from_mem))
		else $error("frame end on a non-data result");

	a_ref_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REF) |-> $past(ref_active_q))
		else $error("refresh data read while refresh idle");
`endif

endmodule

`default_nettype wire
